[src/ssr_pkg.sv]
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants of the single-wire sensor responder
// Holds the phase encoding, the configuration set, and the result fields.
// ----------------------------------------------------------------------------
package ssr_pkg;

    // Width of every configuration register and of the phase tick counter.
    localparam int unsigned REG_WIDTH   = 16;
    localparam int unsigned FRAME_BITS  = 40;
    localparam int unsigned BIT_CNT_W   = 6;

    localparam logic [REG_WIDTH-1:0] RELEASE_TICKS = 16'd10;

    // Reset values of the configuration registers.
    localparam logic [REG_WIDTH-1:0] RST_START_MIN = 16'd18000;
    localparam logic [REG_WIDTH-1:0] RST_START_MAX = 16'd30000;
    localparam logic [REG_WIDTH-1:0] RST_ACK_LOW   = 16'd80;
    localparam logic [REG_WIDTH-1:0] RST_ACK_HIGH  = 16'd80;
    localparam logic [REG_WIDTH-1:0] RST_BIT_LOW   = 16'd50;
    localparam logic [REG_WIDTH-1:0] RST_ZERO_HIGH = 16'd26;
    localparam logic [REG_WIDTH-1:0] RST_ONE_HIGH  = 16'd70;
    localparam logic [REG_WIDTH-1:0] RST_STOP_LOW  = 16'd50;

    // Reading held after reset.
    localparam logic [7:0] RST_HUMIDITY    = 8'd50;
    localparam logic [7:0] RST_TEMPERATURE = 8'd25;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_START_MIN = 3'd0,
        CFG_START_MAX = 3'd1,
        CFG_ACK_LOW   = 3'd2,
        CFG_ACK_HIGH  = 3'd3,
        CFG_BIT_LOW   = 3'd4,
        CFG_ZERO_HIGH = 3'd5,
        CFG_ONE_HIGH  = 3'd6,
        CFG_STOP_LOW  = 3'd7
    } t_cfg_idx;

    // Response sequencer phases.
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_ACK_LOW  = 7'b0000010,
        PH_ACK_HIGH = 7'b0000100,
        PH_BIT_LOW  = 7'b0001000,
        PH_BIT_HIGH = 7'b0010000,
        PH_STOP_LOW = 7'b0100000,
        PH_RELEASE  = 7'b1000000
    } t_phase;

    // Current configuration set.
    typedef struct packed {
        logic [REG_WIDTH-1:0] start_min;
        logic [REG_WIDTH-1:0] start_max;
        logic [REG_WIDTH-1:0] ack_low;
        logic [REG_WIDTH-1:0] ack_high;
        logic [REG_WIDTH-1:0] bit_low;
        logic [REG_WIDTH-1:0] zero_high;
        logic [REG_WIDTH-1:0] one_high;
        logic [REG_WIDTH-1:0] stop_low;
    } t_cfg;

    // Result fields of one request.
    typedef struct packed {
        logic drive_low;
        logic responding;
        logic start_detected;
        logic frame_done;
    } t_result;

endpackage

[src/ssr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ssr_cfg_regs: configuration register file
// Eight 16-bit timing registers written through a write-enable port.
// ----------------------------------------------------------------------------
module ssr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [2:0]                    i_index,
    input  logic [ssr_pkg::REG_WIDTH-1:0] i_data,
    output ssr_pkg::t_cfg                 o_cfg
);
    import ssr_pkg::*;

    t_cfg r_cfg;

    // Register writes; an index outside the list changes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_min <= RST_START_MIN;
            r_cfg.start_max <= RST_START_MAX;
            r_cfg.ack_low   <= RST_ACK_LOW;
            r_cfg.ack_high  <= RST_ACK_HIGH;
            r_cfg.bit_low   <= RST_BIT_LOW;
            r_cfg.zero_high <= RST_ZERO_HIGH;
            r_cfg.one_high  <= RST_ONE_HIGH;
            r_cfg.stop_low  <= RST_STOP_LOW;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_index))
                CFG_START_MIN: r_cfg.start_min <= i_data;
                CFG_START_MAX: r_cfg.start_max <= i_data;
                CFG_ACK_LOW:   r_cfg.ack_low   <= i_data;
                CFG_ACK_HIGH:  r_cfg.ack_high  <= i_data;
                CFG_BIT_LOW:   r_cfg.bit_low   <= i_data;
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_data;
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_data;
                CFG_STOP_LOW:  r_cfg.stop_low  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/ssr_core.sv]
// ----------------------------------------------------------------------------
// ssr_core: start listener and response sequencer
// Holds the bus state and advances it by one request per enable.
// ----------------------------------------------------------------------------
module ssr_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_mode,
    input  logic             i_line_level,
    input  logic [7:0]       i_humidity_in,
    input  logic [7:0]       i_temperature_in,
    input  ssr_pkg::t_cfg    i_cfg,
    output ssr_pkg::t_result o_result
);
    import ssr_pkg::*;

    t_phase                 r_phase,     n_phase;
    logic [REG_WIDTH-1:0]   r_ticks,     n_ticks;
    logic [BIT_CNT_W-1:0]   r_bit_count, n_bit_count;
    logic [FRAME_BITS-1:0]  r_frame,     n_frame;
    logic [7:0]             r_humidity,  n_humidity;
    logic [7:0]             r_temp,      n_temp;
    logic                   r_await,     n_await;
    logic [COUNT_WIDTH-1:0] r_low_width, n_low_width;

    logic [REG_WIDTH-1:0]   w_phase_len;
    logic [COUNT_WIDTH-1:0] w_min_ext;
    logic [COUNT_WIDTH-1:0] w_max_ext;
    logic [7:0]             w_sum;
    logic                   w_started;
    logic                   w_done;

    assign w_min_ext = COUNT_WIDTH'(i_cfg.start_min);
    assign w_max_ext = COUNT_WIDTH'(i_cfg.start_max);
    assign w_sum     = r_humidity + r_temp;

    // Length of the current phase; the high time of a bit follows its value.
    always_comb begin
        case (r_phase)
            PH_ACK_LOW:  w_phase_len = i_cfg.ack_low;
            PH_ACK_HIGH: w_phase_len = i_cfg.ack_high;
            PH_BIT_LOW:  w_phase_len = i_cfg.bit_low;
            PH_BIT_HIGH: w_phase_len = r_frame[FRAME_BITS-1] ? i_cfg.one_high
                                                             : i_cfg.zero_high;
            PH_STOP_LOW: w_phase_len = i_cfg.stop_low;
            default:     w_phase_len = RELEASE_TICKS;
        endcase
    end

    // Next state for one request.
    always_comb begin
        n_phase     = r_phase;
        n_ticks     = r_ticks;
        n_bit_count = r_bit_count;
        n_frame     = r_frame;
        n_humidity  = r_humidity;
        n_temp      = r_temp;
        n_await     = r_await;
        n_low_width = r_low_width;
        w_started   = 1'b0;
        w_done      = 1'b0;

        if (i_fire) begin
            if (i_mode) begin
                // A new reading is only stored; no time passes.
                n_humidity = i_humidity_in;
                n_temp     = i_temperature_in;
            end else if (r_phase == PH_IDLE) begin
                // Measure low pulses while listening.
                if (!r_await) begin
                    if (!i_line_level) begin
                        n_await     = 1'b1;
                        n_low_width = COUNT_WIDTH'(1);
                    end
                end else if (!i_line_level) begin
                    if (r_low_width != '1) begin
                        n_low_width = r_low_width + COUNT_WIDTH'(1);
                    end
                end else begin
                    n_await = 1'b0;
                    if (r_low_width >= w_min_ext && r_low_width <= w_max_ext) begin
                        n_frame     = {r_humidity, 8'h00, r_temp, 8'h00, w_sum};
                        n_bit_count = '0;
                        n_phase     = PH_ACK_LOW;
                        n_ticks     = REG_WIDTH'(1);
                        w_started   = 1'b1;
                    end
                end
            end else if (r_ticks < w_phase_len) begin
                n_ticks = r_ticks + REG_WIDTH'(1);
            end else begin
                n_ticks = REG_WIDTH'(1);
                case (r_phase)
                    PH_ACK_LOW:  n_phase = PH_ACK_HIGH;
                    PH_ACK_HIGH: n_phase = PH_BIT_LOW;
                    PH_BIT_LOW:  n_phase = PH_BIT_HIGH;
                    PH_BIT_HIGH: begin
                        n_frame     = {r_frame[FRAME_BITS-2:0], 1'b0};
                        n_bit_count = r_bit_count + BIT_CNT_W'(1);
                        n_phase     = (n_bit_count < BIT_CNT_W'(FRAME_BITS)) ? PH_BIT_LOW
                                                                             : PH_STOP_LOW;
                    end
                    PH_STOP_LOW: n_phase = PH_RELEASE;
                    default: begin
                        // End of release: back to listening, and this sample
                        // already counts toward the next low pulse.
                        n_phase     = PH_IDLE;
                        n_ticks     = '0;
                        w_done      = 1'b1;
                        n_await     = !i_line_level;
                        n_low_width = i_line_level ? '0 : COUNT_WIDTH'(1);
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
            r_bit_count <= '0;
            r_frame     <= '0;
            r_humidity  <= RST_HUMIDITY;
            r_temp      <= RST_TEMPERATURE;
            r_await     <= 1'b0;
            r_low_width <= '0;
        end else begin
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_bit_count <= n_bit_count;
            r_frame     <= n_frame;
            r_humidity  <= n_humidity;
            r_temp      <= n_temp;
            r_await     <= n_await;
            r_low_width <= n_low_width;
        end
    end

    // Result fields reflect the state after this request.
    always_comb begin
        o_result.drive_low      = (n_phase == PH_ACK_LOW) || (n_phase == PH_BIT_LOW) ||
                                  (n_phase == PH_STOP_LOW);
        o_result.responding     = (n_phase != PH_IDLE);
        o_result.start_detected = w_started;
        o_result.frame_done     = w_done;
    end

endmodule

[src/sensor_single_wire_responder.sv]
// ----------------------------------------------------------------------------
// sensor_single_wire_responder: sensor side of a single-wire humidity bus
// Measures host start pulses on one-microsecond ticks and plays back the
// acknowledge, the 40-bit reading frame, the stop low and the release.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    i_mode, i_line_level,
//                                                  i_humidity_in, i_temperature_in
//  out       output     o_out_valid / i_out_ready  o_drive_low, o_responding,
//                                                  o_start_detected, o_frame_done
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One request per clock cycle while the output is not stalled; each accepted
//  request passes the input register, then the result register, before its
//  result is offered.
//  The bus state is updated by short logic between those two registers.
//  Reset is synchronous; configuration is always ready.
//  A stalled output holds its result and backs up into the input register.
// ----------------------------------------------------------------------------
module sensor_single_wire_responder #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic                          i_line_level,
    input  logic [7:0]                    i_humidity_in,
    input  logic [7:0]                    i_temperature_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_drive_low,
    output logic                          o_responding,
    output logic                          o_start_detected,
    output logic                          o_frame_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [ssr_pkg::REG_WIDTH-1:0] i_cfg_data
);
    import ssr_pkg::*;

    logic       r_in_valid;
    logic       r_mode;
    logic       r_line_level;
    logic [7:0] r_humidity_in;
    logic [7:0] r_temperature_in;
    logic       r_out_valid;
    t_result    r_result;

    logic       w_out_load;
    logic       w_fire;
    t_cfg       w_cfg;
    t_result    w_result;

    // Handshake control: the result register frees up when taken.
    assign w_out_load = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_load;
    assign o_in_ready = !r_in_valid || w_out_load;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode           <= i_mode;
            r_line_level     <= i_line_level;
            r_humidity_in    <= i_humidity_in;
            r_temperature_in <= i_temperature_in;
        end
    end

    ssr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    ssr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_mode           (r_mode),
        .i_line_level     (r_line_level),
        .i_humidity_in    (r_humidity_in),
        .i_temperature_in (r_temperature_in),
        .i_cfg            (w_cfg),
        .o_result         (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive_low      = r_result.drive_low;
    assign o_responding     = r_result.responding;
    assign o_start_detected = r_result.start_detected;
    assign o_frame_done     = r_result.frame_done;

endmodule
